// ----- hw/rtl/static_table_range_encoder_top_assert.svh -----
// Assertion macros used by the range encoder coder.
// Each macro takes a label, a clock, a reset, the conditions and a message.
`ifndef STATIC_TABLE_RANGE_ENCODER_TOP_ASSERT_SVH
`define STATIC_TABLE_RANGE_ENCODER_TOP_ASSERT_SVH

// Same-cycle implication.
`define STRE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define STRE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/stre_pkg.sv -----
package stre_pkg;

  localparam int RANGE_PRECISION = 15;
  localparam int ALPHABET_SIZE   = 257;
  localparam int TABLE_DEPTH     = ALPHABET_SIZE + 1;
  localparam int TABLE_AW        = $clog2(TABLE_DEPTH);
  localparam int RENORM_SHIFT    = 24 - RANGE_PRECISION;

  localparam logic [63:0] FLOOR_RANGE = 64'd1 << (33 - RANGE_PRECISION);
  localparam logic [63:0] TOP_MASK    = 64'd255 << 56;
  localparam logic [63:0] RESET_RANGE = 64'h8000_0000_0000_0000;
  localparam logic [7:0]  ESC_BYTE    = 8'd255;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_BYTE   = 2'd1,
    CMD_FINISH = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_LO,
    S_MUL_W,
    S_FIN,
    S_FL_HI,
    S_FL_OUT
  } coder_state_t;

  // Start values and a restart strobe from the register block.
  typedef struct packed {
    logic        restart;
    logic [62:0] start_low;
    logic [63:0] start_range;
  } cfg_t;

  // One group of results: optional leading carry, up to eight bytes taken
  // from the top of word, optional trailing carry.
  typedef struct packed {
    logic        carry_first;
    logic [3:0]  nbytes;
    logic [63:0] word;
    logic        carry_last;
  } burst_t;

endpackage

// ----- hw/rtl/stre_coder.sv -----
`include "static_table_range_encoder_top_assert.svh"

module stre_coder (
  input  logic           clk,
  input  logic           rst,
  input  stre_pkg::cfg_t cfg,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     in_cmd,
  input  logic [8:0]     in_index,
  input  logic [15:0]    in_value,
  input  logic [7:0]     in_byte,
  output logic           burst_valid,
  input  logic           burst_ready,
  output stre_pkg::burst_t burst
);
  import stre_pkg::*;

  logic [15:0] mem [0:TABLE_DEPTH-1];
  logic [15:0] rd_lo;
  logic [15:0] rd_hi;

  coder_state_t state;
  coder_state_t state_next;

  logic [63:0] low;
  logic [63:0] range;
  logic [63:0] lar;
  logic        esc;
  logic [47:0] pl;
  logic [47:0] ph;
  logic [63:0] hi;
  logic        cf_fl;

  logic          accept;
  logic          esc_live;
  logic [8:0]    sym_raw;
  logic [8:0]    sym;
  logic          is_escape;
  logic [15:0]   mul_op;
  logic [47:0]   pl_next;
  logic [47:0]   ph_next;
  logic [63:0]   prod;
  logic [63:0]   range_nxt;
  logic          renorm;
  logic          hi_gt;
  logic [3:0]    lzb;

  // Count of leading bytes in which low and hi agree.
  function automatic logic [3:0] lead_zero_bytes(input logic [63:0] diff);
    logic [3:0] k;
    logic       done;
    k    = 4'd0;
    done = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (!done && (((diff << (8 * i)) & TOP_MASK) == 64'd0)) begin
        k = k + 4'd1;
      end else begin
        done = 1'b1;
      end
    end
    return k;
  endfunction

  assign accept    = in_valid && in_ready;
  // A register write drops a pending escape in the same cycle as the restart.
  assign esc_live  = esc && !cfg.restart;
  assign sym_raw   = esc_live ? ({1'b0, in_byte} + 9'd1) : {1'b0, in_byte};
  assign sym       = (sym_raw > 9'(ALPHABET_SIZE - 1)) ? 9'(ALPHABET_SIZE - 1) : sym_raw;
  assign is_escape = !esc_live && (in_byte == ESC_BYTE);

  // One shared 64x16 product, split into two 32x16 halves.
  assign mul_op    = (state == S_MUL_LO) ? rd_lo : (rd_hi - rd_lo);
  assign pl_next   = 48'(range[31:0]) * 48'(mul_op);
  assign ph_next   = 48'(range[63:32]) * 48'(mul_op);
  assign prod      = {16'd0, pl} + {ph[31:0], 32'd0};
  assign range_nxt = prod >> RANGE_PRECISION;
  assign renorm    = range_nxt <= FLOOR_RANGE;
  assign hi_gt     = hi > low;
  assign lzb       = lead_zero_bytes(low ^ hi);

  always_ff @(posedge clk) begin
    if (accept && (in_cmd == CMD_BYTE)) begin
      rd_lo <= mem[sym];
      rd_hi <= mem[sym + 9'd1];
    end
    if (accept && (in_cmd == CMD_LOAD) && (in_index < 9'(TABLE_DEPTH))) begin
      mem[in_index] <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    burst_valid = 1'b0;
    burst       = '0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_MUL_LO: begin
        state_next = S_MUL_W;
      end
      S_MUL_W: begin
        state_next = S_FIN;
      end
      S_FIN: begin
        if (renorm) begin
          burst_valid       = 1'b1;
          burst.carry_first = low < lar;
          burst.nbytes      = 4'd3;
          burst.word        = {low[63:40], 40'd0};
          in_ready          = burst_ready;
          if (burst_ready) begin
            state_next = S_IDLE;
          end
        end else begin
          in_ready   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_FL_HI: begin
        state_next = S_FL_OUT;
      end
      S_FL_OUT: begin
        burst_valid       = 1'b1;
        burst.carry_first = cf_fl;
        burst.nbytes      = hi_gt ? (lzb + 4'd1) : 4'd0;
        burst.word        = hi;
        burst.carry_last  = !hi_gt;
        in_ready          = burst_ready;
        if (burst_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (accept) begin
      case (in_cmd)
        CMD_BYTE: begin
          if (!is_escape) begin
            state_next = S_MUL_LO;
          end
        end
        CMD_FINISH: begin
          state_next = S_FL_HI;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_MUL_LO) || (state == S_MUL_W)) begin
      pl <= pl_next;
      ph <= ph_next;
    end
    if (state == S_FL_HI) begin
      hi    <= low + ((range << RANGE_PRECISION) - 64'd1);
      cf_fl <= low < lar;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low   <= 64'd0;
      range <= RESET_RANGE >> (RANGE_PRECISION - 1);
      lar   <= 64'd0;
      esc   <= 1'b0;
    end else begin
      if (cfg.restart || ((state == S_FL_OUT) && burst_ready)) begin
        low   <= {cfg.start_low, 1'b0};
        range <= cfg.start_range >> (RANGE_PRECISION - 1);
        lar   <= {cfg.start_low, 1'b0};
        esc   <= 1'b0;
      end
      if (state == S_MUL_W) begin
        low <= low + {16'd0, pl} + {ph[31:0], 32'd0};
      end
      if (state == S_FIN) begin
        if (!renorm) begin
          range <= range_nxt;
        end else if (burst_ready) begin
          low   <= low << 24;
          lar   <= low << 24;
          range <= prod << RENORM_SHIFT;
        end
      end
      // A new item after the flush wins over the restart. A finish drops a
      // pending escape as soon as it is taken.
      if (accept && (in_cmd == CMD_BYTE)) begin
        esc <= is_escape;
      end else if (accept && (in_cmd == CMD_FINISH)) begin
        esc <= 1'b0;
      end
    end
  end

  `STRE_ASSERT_NOW(a_burst_state, clk, rst, burst_valid,
    (state == S_FIN) || (state == S_FL_OUT), "burst offered outside a finishing state")
  `STRE_ASSERT_NOW(a_no_accept_busy, clk, rst,
    (state == S_MUL_LO) || (state == S_MUL_W) || (state == S_FL_HI), !in_ready,
    "item accepted while the coder recurrence is in flight")
  `STRE_ASSERT_NEXT(a_symbol_starts, clk, rst,
    accept && (in_cmd == CMD_BYTE) && !is_escape, state == S_MUL_LO,
    "coded symbol did not start the multiply sequence")
  `STRE_ASSERT_NOW(a_flush_nonempty, clk, rst, burst_valid && (state == S_FL_OUT),
    ((burst.nbytes != 4'd0) || burst.carry_last) && (burst.nbytes <= 4'd8),
    "flush burst is empty or too long")

endmodule

// ----- hw/rtl/stre_emit.sv -----
module stre_emit (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  stre_pkg::burst_t in_burst,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_kind,
  output logic [7:0]       out_byte,
  output logic             out_last
);
  import stre_pkg::*;

  logic        cf;
  logic [3:0]  nb;
  logic [63:0] word;
  logic        cl;
  logic        take;

  assign out_valid = cf || (nb != 4'd0) || cl;
  assign out_kind  = cf || (nb == 4'd0);
  assign out_byte  = out_kind ? 8'd0 : word[63:56];
  always_comb begin
    if (cf) begin
      out_last = (nb == 4'd0) && !cl;
    end else if (nb != 4'd0) begin
      out_last = (nb == 4'd1) && !cl;
    end else begin
      out_last = 1'b1;
    end
  end

  assign take     = out_valid && out_ready;
  assign in_ready = !out_valid || (take && out_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      cf <= 1'b0;
      nb <= 4'd0;
      cl <= 1'b0;
    end else if (in_valid && in_ready) begin
      cf <= in_burst.carry_first;
      nb <= in_burst.nbytes;
      cl <= in_burst.carry_last;
    end else if (take) begin
      if (cf) begin
        cf <= 1'b0;
      end else if (nb != 4'd0) begin
        nb <= nb - 4'd1;
      end else begin
        cl <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word <= in_burst.word;
    end else if (take && !cf && (nb != 4'd0)) begin
      word <= word << 8;
    end
  end

endmodule

// ----- hw/rtl/static_table_range_encoder_top.sv -----
// Channel   | Direction | Handshake         | Contents
// s_axis    | in        | s_tvalid/s_tready | command, table load or source byte
// m_axis    | out       | m_tvalid/m_tready | coded byte or carry item
// apb       | in/out    | psel/penable      | start_low at 0x0, start_range at 0x8
//
// A table load, an escape byte or an unused command leaves the coder idle. A
// coded symbol reads the table at accept, then makes two passes through the
// shared 64x16 multiplier, and the next item is accepted after them. A finish
// forms the closing sum, then the byte count and hand-over. Reset is
// synchronous and active high and leaves the table uncleared. The coder
// stalls only while the output stage is still draining the last group.
module static_table_range_encoder_top (
  input  logic        clk,
  input  logic        rst,
  // s_tdata: table_index [8:0], table_value [24:9], src_byte [32:25], zero [39:33]
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,
  // s_tuser: command [1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // m_tdata: out_byte [7:0]
  output logic [7:0]  m_tdata,
  // m_tuser: out_kind [0]
  output logic        m_tuser,
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import stre_pkg::*;

  logic [62:0] start_low;
  logic [63:0] start_range;
  logic        apb_write;
  logic        restart;
  cfg_t        cfg;
  logic        burst_valid;
  logic        burst_ready;
  burst_t      burst;

  // Register select uses the 8-byte slot bit only.
  assign pready    = 1'b1;
  assign apb_write = psel && penable && pwrite && pready;
  assign prdata    = paddr[3] ? start_range : {1'b0, start_low};

  always_ff @(posedge clk) begin
    if (rst) begin
      start_low   <= 63'd0;
      start_range <= RESET_RANGE;
    end else if (apb_write) begin
      if (paddr[3]) begin
        start_range <= pwdata;
      end else begin
        start_low <= pwdata[62:0];
      end
    end
  end

  // Any register write restarts the coder from the new start values. The
  // strobe is registered with the value so the coder sees them together.
  always_ff @(posedge clk) begin
    if (rst) begin
      restart <= 1'b0;
    end else begin
      restart <= apb_write;
    end
  end
  assign cfg = '{restart: restart, start_low: start_low, start_range: start_range};

  stre_coder u_coder (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_cmd      (s_tuser),
    .in_index    (s_tdata[8:0]),
    .in_value    (s_tdata[24:9]),
    .in_byte     (s_tdata[32:25]),
    .burst_valid (burst_valid),
    .burst_ready (burst_ready),
    .burst       (burst)
  );

  stre_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (burst_valid),
    .in_ready  (burst_ready),
    .in_burst  (burst),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_kind  (m_tuser),
    .out_byte  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

// ----- bench/static_table_range_encoder_top_test.sv -----
`timescale 1ns / 1ps

module static_table_range_encoder_top_test;
  import stre_pkg::*;

  // Command code that the encoder must ignore.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Register byte addresses: each register is 64 bits wide, so they lie 8 apart.
  localparam logic [3:0] ADDR_START_LOW   = 4'h0;
  localparam logic [3:0] ADDR_START_RANGE = 4'h8;

  localparam logic [63:0] LOW_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] LOW_MASK  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int          SETTLE    = 16;
  localparam int          DRAIN_MAX = 20000;

  // One output item as the encoder should produce it.
  typedef struct packed {
    logic       is_carry;
    logic [7:0] code_byte;
    logic       ends_item;
  } coded_item_t;

  // Scoreboard: holds its own copy of the coder state, works out the coded
  // items for every accepted input item and compares them with the output.
  class coded_stream_board;
    logic [15:0] cum_freq [TABLE_DEPTH];
    logic [63:0] start_low;
    logic [63:0] start_span;
    logic [63:0] low;
    logic [63:0] span;
    logic [63:0] renorm_low;
    bit          escape_seen;
    coded_item_t expected_codes [$];
    int          mismatches;
    int          checked;
    int          carries;

    function new();
      foreach (cum_freq[i]) cum_freq[i] = '0;
      start_low  = '0;
      start_span = RESET_RANGE;
      mismatches = 0;
      checked    = 0;
      carries    = 0;
      restart();
    endfunction

    function void restart();
      low         = {start_low[62:0], 1'b0};
      span        = start_span >> (RANGE_PRECISION - 1);
      renorm_low  = low;
      escape_seen = 1'b0;
    endfunction

    function void write_register(logic [3:0] addr, logic [63:0] value);
      if (addr == ADDR_START_LOW) begin
        start_low = value & LOW_MASK;
        restart();
      end else if (addr == ADDR_START_RANGE) begin
        start_span = value;
        restart();
      end
    endfunction

    function void push_code(logic is_carry, logic [7:0] code_byte);
      coded_item_t c;
      c.is_carry  = is_carry;
      c.code_byte = code_byte;
      c.ends_item = 1'b0;
      expected_codes.push_back(c);
    endfunction

    // Narrow low and span by one symbol, renormalizing at the floor.
    function void encode_symbol(int unsigned sym);
      logic [63:0] lo_b;
      logic [63:0] width;
      logic [63:0] narrowed;
      logic [15:0] w16;
      if (sym > ALPHABET_SIZE - 1) sym = ALPHABET_SIZE - 1;
      lo_b     = 64'(cum_freq[sym]);
      w16      = cum_freq[sym + 1] - cum_freq[sym];
      width    = 64'(w16);
      low      = low + span * lo_b;
      span     = span * width;
      narrowed = span >> RANGE_PRECISION;
      if (narrowed <= FLOOR_RANGE) begin
        if (low < renorm_low) push_code(1'b1, 8'h00);
        push_code(1'b0, low[63:56]);
        push_code(1'b0, low[55:48]);
        push_code(1'b0, low[47:40]);
        low        = low << 24;
        narrowed   = span << RENORM_SHIFT;
        renorm_low = low;
      end
      span = narrowed;
    endfunction

    // Closing bytes: enough of the top of the final interval to pin it down.
    function void encode_flush();
      logic [63:0] hi;
      logic [63:0] diff;
      if (low < renorm_low) push_code(1'b1, 8'h00);
      hi = low + ((span << RANGE_PRECISION) - 64'd1);
      if (hi > low) begin
        diff = low ^ hi;
        while ((diff & TOP_MASK) == 64'd0) begin
          push_code(1'b0, hi[63:56]);
          hi   = hi << 8;
          diff = diff << 8;
        end
        push_code(1'b0, hi[63:56]);
      end else begin
        push_code(1'b1, 8'h00);
      end
      restart();
    endfunction

    function void note_input(logic [1:0] cmd, logic [8:0] idx, logic [15:0] val,
                             logic [7:0] src);
      int queued;
      queued = expected_codes.size();
      case (cmd)
        CMD_LOAD: begin
          if (idx < TABLE_DEPTH) cum_freq[idx] = val;
        end
        CMD_BYTE: begin
          if (escape_seen) begin
            escape_seen = 1'b0;
            encode_symbol(int'(src) + 1);
          end else if (src == ESC_BYTE) begin
            escape_seen = 1'b1;
          end else begin
            encode_symbol(int'(src));
          end
        end
        CMD_FINISH: encode_flush();
        default: ;
      endcase
      if (expected_codes.size() > queued)
        expected_codes[expected_codes.size() - 1].ends_item = 1'b1;
    endfunction

    function void check_code(logic is_carry, logic [7:0] code_byte, logic ends_item);
      coded_item_t want;
      checked++;
      if (is_carry === 1'b1) carries++;
      if (expected_codes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected output item: kind %0d byte %02h last %0d",
                   is_carry, code_byte, ends_item);
        return;
      end
      want = expected_codes.pop_front();
      if (want.is_carry !== is_carry || want.code_byte !== code_byte ||
          want.ends_item !== ends_item) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Item %0d: want kind %0d byte %02h last %0d, got %0d %02h %0d",
                   checked, want.is_carry, want.code_byte, want.ends_item,
                   is_carry, code_byte, ends_item);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata  = '0;
  logic [1:0]  s_tuser  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [3:0]  paddr    = '0;
  logic [63:0] pwdata   = '0;
  logic [63:0] prdata;
  logic        pready;

  coded_stream_board board;

  // When set, neither side inserts gaps or stalls.
  bit          no_idle = 1'b0;
  // When set, the loaded table has one dominant symbol, hot_sym.
  bit          skewed  = 1'b0;
  int          hot_sym = 0;
  int          items_sent = 0;
  int          settings_run = 0;
  logic [15:0] table_now [TABLE_DEPTH];

  static_table_range_encoder_top u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Output side: every accepted output item is checked against the oldest
  // expected one. Values are read just after the edge, so they are the ones
  // the encoder saw at that edge.
  always @(posedge clk) begin
    if (!rst && m_tvalid === 1'b1 && m_tready)
      board.check_code(m_tuser, m_tdata, m_tlast);
  end

  // Receiver: for every output item it draws a stall with tready low, then
  // holds tready high until an item is taken. tready is only lowered at the
  // start of a stall, so it never toggles twice in a step.
  initial begin
    int stall;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
    end
  end

  // Sender: waits its drawn gap, presents the item and holds it until the
  // encoder takes it. The task returns in the step of acceptance; tvalid is
  // left high so that a back-to-back item needs no second assignment, and
  // whatever runs next either lowers it or replaces the item.
  task automatic send_item(logic [1:0] cmd, logic [8:0] idx, logic [15:0] val,
                           logic [7:0] src);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {7'd0, src, val, idx};
    do @(posedge clk); while (s_tready !== 1'b1);
    board.note_input(cmd, idx, val, src);
    items_sent++;
  endtask

  // Code one symbol, taking the escape route where it is the only way or,
  // now and then, where a plain byte would also do.
  task automatic send_symbol(int sym);
    if (sym >= ALPHABET_SIZE - 2 || (sym > 0 && $urandom_range(0, 9) == 0)) begin
      send_item(CMD_BYTE, 9'($urandom), 16'($urandom), ESC_BYTE);
      send_item(CMD_BYTE, 9'($urandom), 16'($urandom), 8'(sym - 1));
    end else begin
      send_item(CMD_BYTE, 9'($urandom), 16'($urandom), 8'(sym));
    end
  endtask

  // Pause the sender until every expected item has come out, then give the
  // encoder time to finish items that cause no output.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (board.expected_codes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle held until pready. psel is then
  // held low over an edge so that psel never falls and rises in the same step.
  task automatic write_reg(logic [3:0] addr, logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    board.write_register(addr, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Load a full cumulative table. The even shape has 258 strictly rising
  // bounds, 256 at random places; the skewed shape gives one symbol almost all
  // of the range and every other symbol a width of one.
  task automatic load_table(bit dominant);
    int cuts [$];
    int cum;
    cuts.delete();
    skewed = dominant;
    if (dominant) begin
      hot_sym = $urandom_range(0, ALPHABET_SIZE - 1);
      cum = 0;
      for (int i = 0; i < ALPHABET_SIZE; i++) begin
        table_now[i] = 16'(cum);
        cum += (i == hot_sym) ? (32768 - (ALPHABET_SIZE - 1)) : 1;
      end
    end else begin
      for (int i = 1; i < ALPHABET_SIZE; i++) cuts.push_back($urandom_range(1, 32767));
      cuts.sort();
      table_now[0] = 16'd0;
      for (int i = 1; i < ALPHABET_SIZE; i++) table_now[i] = 16'(cuts[i - 1]);
      table_now[ALPHABET_SIZE] = 16'd32768;
      // Make the bounds strictly rising without passing the full range.
      for (int i = 1; i < ALPHABET_SIZE; i++)
        if (table_now[i] <= table_now[i - 1]) table_now[i] = table_now[i - 1] + 16'd1;
      for (int i = ALPHABET_SIZE - 1; i > 0; i--)
        if (table_now[i] >= table_now[i + 1]) table_now[i] = table_now[i + 1] - 16'd1;
    end
    table_now[ALPHABET_SIZE] = 16'd32768;
    for (int i = 0; i < TABLE_DEPTH; i++)
      send_item(CMD_LOAD, 9'(i), table_now[i], 8'($urandom));
  endtask

  // Directed part: field extremes, every command and the special cases.
  task automatic run_directed();
    // Lowest and highest plain symbols, then the escaped symbols.
    send_item(CMD_BYTE, 9'd0, 16'd0, 8'd0);
    send_item(CMD_BYTE, 9'h1FF, 16'hFFFF, 8'd254);
    send_item(CMD_BYTE, 9'd0, 16'd0, ESC_BYTE);
    send_item(CMD_BYTE, 9'd0, 16'd0, 8'd0);
    send_item(CMD_BYTE, 9'd0, 16'd0, ESC_BYTE);
    send_item(CMD_BYTE, 9'd0, 16'd0, 8'd255);
    send_item(CMD_BYTE, 9'd0, 16'd0, ESC_BYTE);
    send_item(CMD_BYTE, 9'd0, 16'd0, 8'd254);
    send_item(CMD_BYTE, 9'h0AA, 16'h5555, 8'h55);
    send_item(CMD_BYTE, 9'h155, 16'hAAAA, 8'hAA);
    // Loads past the end of the table and the unused command do nothing.
    send_item(CMD_LOAD, 9'd258, 16'd0, 8'd0);
    send_item(CMD_LOAD, 9'h1FF, 16'd32768, 8'hFF);
    send_item(CMD_UNUSED, 9'h1FF, 16'hFFFF, 8'hFF);
    // A flush, then a flush of a coder that has just restarted.
    send_item(CMD_FINISH, 9'd0, 16'd0, 8'd0);
    send_item(CMD_FINISH, 9'h1FF, 16'hFFFF, 8'hFF);
    // A pending escape is dropped by the flush, so byte 7 codes symbol 7.
    send_item(CMD_BYTE, 9'd0, 16'd0, ESC_BYTE);
    send_item(CMD_FINISH, 9'd0, 16'd0, 8'd0);
    send_item(CMD_BYTE, 9'd0, 16'd0, 8'd7);
    // A bound below its predecessor: symbol 99 gets a width that wraps and
    // symbol 100 a low bound under that of symbol 99.
    send_item(CMD_LOAD, 9'd100, table_now[99] - 16'd5, 8'd0);
    send_item(CMD_BYTE, 9'd0, 16'd0, 8'd99);
    send_item(CMD_BYTE, 9'd0, 16'd0, 8'd100);
    send_item(CMD_LOAD, 9'd100, table_now[100], 8'd0);
    send_item(CMD_FINISH, 9'd0, 16'd0, 8'd0);
  endtask

  // Random part: mostly symbols, with a few stray loads, flushes and unused
  // commands mixed in. On a skewed table half the symbols are the hot one.
  task automatic random_item();
    int pick;
    int sym;
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      send_item(CMD_LOAD, 9'($urandom_range(0, 300)), 16'($urandom_range(0, 32768)),
                8'($urandom));
    end else if (pick < 7) begin
      send_item(CMD_FINISH, 9'($urandom), 16'($urandom), 8'($urandom));
    end else if (pick < 9) begin
      send_item(CMD_UNUSED, 9'($urandom), 16'($urandom), 8'($urandom));
    end else begin
      if (skewed && $urandom_range(0, 1) == 1) sym = hot_sym;
      else sym = $urandom_range(0, ALPHABET_SIZE - 1);
      send_symbol(sym);
    end
  endtask

  // One setting of the start registers: drain, write both registers while
  // the encoder is idle, run random items and close with a flush.
  task automatic run_phase(bit quiet, logic [63:0] lo, logic [63:0] rg, int count);
    wait_drained();
    no_idle = quiet;
    write_reg(ADDR_START_LOW, lo);
    write_reg(ADDR_START_RANGE, rg);
    settings_run++;
    for (int i = 0; i < count; i++) random_item();
    send_item(CMD_FINISH, 9'($urandom), 16'($urandom), 8'($urandom));
  endtask

  function automatic logic [63:0] random_low();
    return {$urandom, $urandom} & LOW_MASK;
  endfunction

  function automatic logic [63:0] random_span();
    logic [63:0] r;
    r = {$urandom, $urandom} >> $urandom_range(1, 63);
    if (r == 64'd0) r = 64'd1;
    return r;
  endfunction

  // Safety net against a hung handshake.
  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int waited;
    board = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset values of both registers, an even table, then the directed items.
    write_reg(ADDR_START_LOW, 64'd0);
    write_reg(ADDR_START_RANGE, RESET_RANGE);
    settings_run++;
    load_table(1'b0);
    run_directed();

    // Settings sweep; a start range of one leaves no span at all, so every
    // symbol renormalizes, and a top start low makes low wrap early.
    run_phase(1'b0, 64'd0, RESET_RANGE, 30);
    run_phase(1'b0, LOW_MAX, RESET_RANGE, 30);
    run_phase(1'b1, random_low(), random_span(), 30);
    run_phase(1'b0, random_low(), RESET_RANGE, 30);
    run_phase(1'b0, 64'd0, 64'd1, 15);
    run_phase(1'b1, random_low(), random_span(), 30);
    run_phase(1'b0, LOW_MAX, 64'd1, 15);
    run_phase(1'b0, random_low(), random_span(), 20);

    // Let the last output items come out, with a bound on the wait.
    s_tvalid <= 1'b0;
    waited = 0;
    while (board.expected_codes.size() != 0 && waited < DRAIN_MAX) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE) @(posedge clk);
    if (board.expected_codes.size() != 0) begin
      $display("%0d expected output items never came out", board.expected_codes.size());
      board.mismatches += board.expected_codes.size();
    end

    $display("Sent %0d input items over %0d register settings on an even table.",
             items_sent, settings_run);
    $display("Checked %0d output items, %0d of them carries.", board.checked, board.carries);
    if (board.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/stre_pkg.sv
hw/rtl/stre_coder.sv
hw/rtl/stre_emit.sv
hw/rtl/static_table_range_encoder_top.sv
bench/static_table_range_encoder_top_test.sv
